### hw/rtl/tts_pkg.sv
package tts_pkg;

    // Screen geometry and tab spacing.
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_STOP    = 8;

    // Field widths of the command and result words.
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 24;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam int CELL_DEPTH = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W     = $clog2(CELL_DEPTH);

    localparam int QUEUE_DEPTH = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

    // Byte codes.
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

    localparam logic [COLOR_W-1:0] FG_RESET = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BG_RESET = 24'h000000;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    localparam cell_t CELL_BLANK = '{ch: 8'h20, fg: 24'hFFFFFF, bg: 24'h000000};

    // Operation decoded by the front end.
    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACK,
        OP_TAB,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WRITE,
        ST_READ,
        ST_WAIT
    } state_t;

    // Physical row of a logical row, given the physical row shown at the top.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] row);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
            sum = sum - (ROW_W+1)'(SCREEN_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(col);
    endfunction

endpackage

### hw/rtl/tts_if.sv
interface tts_item_if;
    import tts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] byte_value;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (output valid, output cmd, output byte_value, output read_row,
                    output read_col, input ready);
    modport sink (input valid, input cmd, input byte_value, input read_row,
                  input read_col, output ready);
endinterface

interface tts_result_if;
    import tts_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_fg;
    logic [COLOR_W-1:0] cell_bg;
    logic [COL_W-1:0]   cursor_column;
    logic [ROW_W-1:0]   cursor_line;

    modport source (output valid, output cell_char, output cell_fg, output cell_bg,
                    output cursor_column, output cursor_line, input ready);
    modport sink (input valid, input cell_char, input cell_fg, input cell_bg,
                  input cursor_column, input cursor_line, output ready);
endinterface

interface tts_cfg_if;
    import tts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/tts_ram.sv
module tts_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/tts_front.sv
module tts_front
    import tts_pkg::*;
(
    tts_item_if.sink item,
    input  logic     full,
    output logic     push,
    output item_t    push_item
);

    op_t put_op;

    // Classify the byte of a put-byte word.
    always_comb
    begin
        case (item.byte_value)
            CH_LF:   put_op = OP_NEWLINE;
            CH_CR:   put_op = OP_RETURN;
            CH_BS:   put_op = OP_BACK;
            CH_TAB:  put_op = OP_TAB;
            default:
            begin
                if (item.byte_value >= CH_PRINT_LO && item.byte_value <= CH_PRINT_HI)
                begin
                    put_op = OP_PRINT;
                end
                else
                begin
                    put_op = OP_NOP;
                end
            end
        endcase
    end

    always_comb
    begin
        case (item.cmd)
            CMD_PUT:   push_item.op = put_op;
            CMD_READ:  push_item.op = OP_READ;
            CMD_CLEAR: push_item.op = OP_CLEAR;
            default:   push_item.op = OP_NOP;
        endcase
        push_item.ch = item.byte_value;

        // Read addresses beyond the screen saturate to the last row or column.
        if ({1'b0, item.read_row} >= (ROW_W+1)'(SCREEN_ROWS))
        begin
            push_item.row = ROW_W'(SCREEN_ROWS - 1);
        end
        else
        begin
            push_item.row = item.read_row;
        end
        if ({1'b0, item.read_col} >= (COL_W+1)'(SCREEN_COLS))
        begin
            push_item.col = COL_W'(SCREEN_COLS - 1);
        end
        else
        begin
            push_item.col = item.read_col;
        end
    end

    assign item.ready = !full;
    assign push       = item.valid && !full;

endmodule

### hw/rtl/tts_queue.sv
module tts_queue
    import tts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/tts_back.sv
module tts_back
    import tts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    tts_cfg_if.sink       cfg,
    tts_result_if.source  result,
    input  logic  empty,
    input  item_t head,
    output logic  pop
);

    state_t                 state_reg, state_next;
    logic [COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]       top_reg, top_next;
    logic [SCREEN_ROWS-1:0] row_valid_reg, row_valid_next;
    logic [COLOR_W-1:0]     fg_reg, bg_reg;

    logic [ROW_W-1:0]       wr_phys_reg, wr_phys_next;
    logic [COL_W-1:0]       wr_col_reg, wr_col_next;
    cell_t                  wr_cell_reg, wr_cell_next;
    logic                   wr_print_reg, wr_print_next;
    logic [COL_W-1:0]       sweep_cnt_reg, sweep_cnt_next;
    logic                   rd_cur_reg, rd_cur_next;
    logic [ROW_W-1:0]       rd_row_reg, rd_row_next;
    logic [COL_W-1:0]       rd_col_reg, rd_col_next;
    logic                   rd_hit_reg, rd_hit_next;

    logic                   out_valid_reg, out_valid_next;
    cell_t                  out_cell_reg, out_cell_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic [ROW_W-1:0]       out_row_reg, out_row_next;

    logic                   out_free;
    logic                   do_lf;
    logic [ROW_W-1:0]       cur_phys;
    logic [ROW_W-1:0]       bs_row;
    logic [COL_W-1:0]       bs_col;
    logic                   bs_move;
    logic [ROW_W-1:0]       bs_phys;
    logic [COL_W:0]         tab_base;
    logic [COL_W:0]         tab_next;
    logic [COL_W-1:0]       tab_col;
    logic [COL_W:0]         col_plus;
    logic [ROW_W-1:0]       rd_row_sel;
    logic [COL_W-1:0]       rd_col_sel;
    logic [ROW_W-1:0]       rd_phys;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    cell_t                  ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [CELL_W-1:0]      ram_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_FG)
            begin
                fg_reg <= cfg.data;
            end
            else if (cfg.index == REG_BG)
            begin
                bg_reg <= cfg.data;
            end
        end
    end

    // Cursor arithmetic shared by the dispatch and write states.
    assign cur_phys = phys_row(top_reg, cur_row_reg);
    assign col_plus = {1'b0, cur_col_reg} + 1'b1;

    assign tab_base = (COL_W+1)'({1'b0, cur_col_reg} / (COL_W+1)'(TAB_STOP));
    assign tab_next = (COL_W+1)'((tab_base + 1'b1) * (COL_W+1)'(TAB_STOP));
    assign tab_col  = (tab_next >= (COL_W+1)'(SCREEN_COLS)) ? COL_W'(SCREEN_COLS - 1)
                                                          : tab_next[COL_W-1:0];

    always_comb
    begin
        bs_move = 1'b1;
        bs_row  = cur_row_reg;
        bs_col  = cur_col_reg;
        if (cur_col_reg != '0)
        begin
            bs_col = cur_col_reg - 1'b1;
        end
        else if (cur_row_reg != '0)
        begin
            bs_row = cur_row_reg - 1'b1;
            bs_col = COL_W'(SCREEN_COLS - 1);
        end
        else
        begin
            bs_move = 1'b0;
        end
    end

    assign bs_phys = phys_row(top_reg, bs_row);

    assign rd_row_sel = rd_cur_reg ? cur_row_reg : rd_row_reg;
    assign rd_col_sel = rd_cur_reg ? cur_col_reg : rd_col_reg;
    assign rd_phys    = phys_row(top_reg, rd_row_sel);
    assign ram_raddr  = cell_addr(rd_phys, rd_col_sel);
    assign ram_waddr  = cell_addr(wr_phys_reg,
                                  (state_reg == ST_SWEEP) ? sweep_cnt_reg : wr_col_reg);

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        wr_phys_next   = wr_phys_reg;
        wr_col_next    = wr_col_reg;
        wr_cell_next   = wr_cell_reg;
        wr_print_next  = wr_print_reg;
        sweep_cnt_next = sweep_cnt_reg;
        rd_cur_next    = rd_cur_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        rd_hit_next    = rd_hit_reg;
        out_valid_next = out_valid_reg;
        out_cell_next  = out_cell_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        pop            = 1'b0;
        do_lf          = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = wr_cell_reg;
        ram_re         = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop         = 1'b1;
                    rd_cur_next = 1'b1;
                    rd_row_next = head.row;
                    rd_col_next = head.col;
                    state_next  = ST_READ;
                    case (head.op)
                        OP_PRINT:
                        begin
                            wr_phys_next  = cur_phys;
                            wr_col_next   = cur_col_reg;
                            wr_cell_next  = '{ch: head.ch, fg: fg_reg, bg: bg_reg};
                            wr_print_next = 1'b1;
                            // A row that is not valid holds stale data: blank it first.
                            if (row_valid_reg[cur_phys])
                            begin
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                sweep_cnt_next = '0;
                                state_next     = ST_SWEEP;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            do_lf = 1'b1;
                        end
                        OP_RETURN:
                        begin
                            cur_col_next = '0;
                        end
                        OP_BACK:
                        begin
                            cur_col_next = bs_col;
                            cur_row_next = bs_row;
                            // An invalid row already reads as blank, so no write is needed.
                            if (bs_move && row_valid_reg[bs_phys])
                            begin
                                wr_phys_next  = bs_phys;
                                wr_col_next   = bs_col;
                                wr_cell_next  = CELL_BLANK;
                                wr_print_next = 1'b0;
                                state_next    = ST_WRITE;
                            end
                        end
                        OP_TAB:
                        begin
                            cur_col_next = tab_col;
                        end
                        OP_READ:
                        begin
                            rd_cur_next = 1'b0;
                        end
                        OP_CLEAR:
                        begin
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            row_valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                ram_we         = 1'b1;
                ram_wdata      = CELL_BLANK;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == COL_W'(SCREEN_COLS - 1))
                begin
                    row_valid_next[wr_phys_reg] = 1'b1;
                    state_next                  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
                if (wr_print_reg)
                begin
                    if (col_plus == (COL_W+1)'(SCREEN_COLS))
                    begin
                        do_lf = 1'b1;
                    end
                    else
                    begin
                        cur_col_next = col_plus[COL_W-1:0];
                    end
                end
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_re      = 1'b1;
                rd_hit_next = row_valid_reg[rd_phys];
                state_next  = ST_WAIT;
            end
            ST_WAIT:
            begin
                out_valid_next = 1'b1;
                out_cell_next  = rd_hit_reg ? cell_t'(ram_rdata) : CELL_BLANK;
                out_col_next   = cur_col_reg;
                out_row_next   = cur_row_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Line feed: at the bottom the top row pointer rotates and the row that
        // becomes the new bottom line is marked blank.
        if (do_lf)
        begin
            cur_col_next = '0;
            if (cur_row_reg == ROW_W'(SCREEN_ROWS - 1))
            begin
                top_next = (top_reg == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_reg + 1'b1;
                row_valid_next[top_reg] = 1'b0;
            end
            else
            begin
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_phys_reg   <= wr_phys_next;
        wr_col_reg    <= wr_col_next;
        wr_cell_reg   <= wr_cell_next;
        wr_print_reg  <= wr_print_next;
        sweep_cnt_reg <= sweep_cnt_next;
        rd_cur_reg    <= rd_cur_next;
        rd_row_reg    <= rd_row_next;
        rd_col_reg    <= rd_col_next;
        rd_hit_reg    <= rd_hit_next;
        out_cell_reg  <= out_cell_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
    end

    tts_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_DEPTH)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign result.valid         = out_valid_reg;
    assign result.cell_char     = out_cell_reg.ch;
    assign result.cell_fg       = out_cell_reg.fg;
    assign result.cell_bg       = out_cell_reg.bg;
    assign result.cursor_column = out_col_reg;
    assign result.cursor_line   = out_row_reg;

endmodule

### hw/rtl/text_terminal_screen_engine_unit.sv
// Each accepted word waits in the queue; the back end pops it from the idle state and loads the
// result register through the read and wait states, after the write state for a printable byte
// or a blanking backspace, and after a row sweep when a printable byte first lands on a row not
// in use. A new word is popped only in idle with the result register free, one word at a time.
// Reset (rst_n, asynchronous, active low) empties the queue, homes the cursor, restores the
// colors and marks every row as blank through per-row flags: there is no clearing pass.
module text_terminal_screen_engine_unit
    import tts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tts_item_if.sink     item,
    tts_result_if.source result,
    tts_cfg_if.sink      cfg
);

    // The front end decodes each command word into an operation and a saturated read
    // address, and pushes it into a short queue. The back end pops one word at a time
    // and runs it against the cell memory, so the front keeps taking words while the
    // back is busy or the result register waits to be taken, until the queue is full.
    //
    // The screen is kept as a ring of physical rows. A scroll only moves the top-row
    // pointer and flags the new bottom row as blank; clearing the screen drops every
    // row flag at once. A row whose flag is down reads as blank cells, and the first
    // printable byte written to it triggers a blanking sweep of that row before the
    // write, so stale memory contents are never shown.

    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    item_t head;
    logic  empty;

    tts_front u_front (
        .item      (item),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    tts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // The back end owns the cursor, the row flags, the color registers and the
    // cell memory, and holds the result word until the sink takes it.
    tts_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .result (result),
        .empty  (empty),
        .head   (head),
        .pop    (pop)
    );

endmodule

### sim/screen_shadow_check.sv
`timescale 1ns / 1ps

module screen_shadow_check
    import tts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tts_item_if    item,
    tts_result_if  result,
    tts_cfg_if     cfg,
    output int     view_mismatches,
    output int     views_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } screen_view_t;

    // Shadow copy of the screen, cursor and color registers.
    cell_t              screen_cells [SCREEN_ROWS][SCREEN_COLS];
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [COLOR_W-1:0] ink;
    logic [COLOR_W-1:0] paper;

    screen_view_t pending_views[$];
    screen_view_t got_view;
    screen_view_t want_view;
    int           fail_total;

    function automatic void blank_screen();
        for (int r = 0; r < SCREEN_ROWS; r++)
        begin
            for (int c = 0; c < SCREEN_COLS; c++)
            begin
                screen_cells[r][c] = CELL_BLANK;
            end
        end
        cur_col = '0;
        cur_row = '0;
    endfunction

    // Moves to the start of the next row, scrolling everything up at the bottom.
    function automatic void new_line();
        cur_col = '0;
        if (cur_row == ROW_W'(SCREEN_ROWS - 1))
        begin
            for (int r = 0; r < SCREEN_ROWS - 1; r++)
            begin
                screen_cells[r] = screen_cells[r + 1];
            end
            for (int c = 0; c < SCREEN_COLS; c++)
            begin
                screen_cells[SCREEN_ROWS - 1][c] = CELL_BLANK;
            end
        end
        else
        begin
            cur_row = cur_row + 1'b1;
        end
    endfunction

    function automatic screen_view_t next_screen_view(input logic [CMD_W-1:0]  cmd,
                                                      input logic [CHAR_W-1:0] b,
                                                      input logic [ROW_W-1:0]  rd_row,
                                                      input logic [COL_W-1:0]  rd_col);
        screen_view_t v;
        int           stop;
        int           vr;
        int           vc;
        if (cmd == CMD_PUT)
        begin
            case (b)
                CH_LF: new_line();
                CH_CR: cur_col = '0;
                CH_BS:
                begin
                    if (cur_col != 0)
                    begin
                        cur_col = cur_col - 1'b1;
                        screen_cells[cur_row][cur_col] = CELL_BLANK;
                    end
                    else if (cur_row != 0)
                    begin
                        cur_row = cur_row - 1'b1;
                        cur_col = COL_W'(SCREEN_COLS - 1);
                        screen_cells[cur_row][cur_col] = CELL_BLANK;
                    end
                end
                CH_TAB:
                begin
                    stop = (int'(cur_col) / TAB_STOP + 1) * TAB_STOP;
                    cur_col = (stop >= SCREEN_COLS) ? COL_W'(SCREEN_COLS - 1) : COL_W'(stop);
                end
                default:
                begin
                    if (b >= CH_PRINT_LO && b <= CH_PRINT_HI)
                    begin
                        screen_cells[cur_row][cur_col] = '{ch: b, fg: ink, bg: paper};
                        cur_col = cur_col + 1'b1;
                        if (cur_col >= SCREEN_COLS)
                        begin
                            new_line();
                        end
                    end
                end
            endcase
        end
        else if (cmd == CMD_CLEAR)
        begin
            blank_screen();
        end

        if (cmd == CMD_READ)
        begin
            vr = (rd_row >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : int'(rd_row);
            vc = (rd_col >= SCREEN_COLS) ? SCREEN_COLS - 1 : int'(rd_col);
        end
        else
        begin
            vr = int'(cur_row);
            vc = int'(cur_col);
        end
        v.ch  = screen_cells[vr][vc].ch;
        v.fg  = screen_cells[vr][vc].fg;
        v.bg  = screen_cells[vr][vc].bg;
        v.col = cur_col;
        v.row = cur_row;
        return v;
    endfunction

    function automatic int field_bad(input string name, input logic [COLOR_W-1:0] want,
                                     input logic [COLOR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ink   = FG_RESET;
            paper = BG_RESET;
            blank_screen();
            pending_views.delete();
            fail_total = 0;
            view_mismatches <= 0;
            views_pending   <= 0;
        end
        else
        begin
            // A result word is matched before a new item is queued: the block cannot
            // answer an item in the cycle it takes it.
            if (result.valid && result.ready)
            begin
                got_view = '{ch: result.cell_char, fg: result.cell_fg, bg: result.cell_bg,
                             col: result.cursor_column, row: result.cursor_line};
                if (pending_views.size() == 0)
                begin
                    $display("%0t: result word expected none, actual 0x%0h", $time, got_view);
                    fail_total++;
                end
                else
                begin
                    want_view = pending_views.pop_front();
                    fail_total += field_bad("cell_char", want_view.ch, got_view.ch);
                    fail_total += field_bad("cell_fg", want_view.fg, got_view.fg);
                    fail_total += field_bad("cell_bg", want_view.bg, got_view.bg);
                    fail_total += field_bad("cursor_column", want_view.col, got_view.col);
                    fail_total += field_bad("cursor_line", want_view.row, got_view.row);
                end
            end
            if (item.valid && item.ready)
            begin
                pending_views.push_back(next_screen_view(item.cmd, item.byte_value,
                                                         item.read_row, item.read_col));
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FG:  ink   = cfg.data;
                    REG_BG:  paper = cfg.data;
                    default: ;
                endcase
            end
            view_mismatches <= fail_total;
            views_pending   <= pending_views.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tts_pkg::*;

    // The block has no code for command 3, and only two of the four register
    // indexes are in use. Escape and delete are bytes the block must ignore.
    localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [CHAR_W-1:0]    CH_ESC      = 8'h1B;
    localparam logic [CHAR_W-1:0]    CH_DEL      = 8'h7F;

    // Cycles the result side is held off once, long enough to back up the input.
    localparam int LONG_HOLD    = 150;
    // Settling time after the last expected word has come back.
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_WORDS  = 95;

    logic clk = 1'b0;
    logic rst_n;

    tts_item_if   item_ch();
    tts_result_if result_ch();
    tts_cfg_if    cfg_ch();

    int view_mismatches;
    int views_pending;

    // Number of words sent that the block acts on; ignored bytes do not count.
    int counted_words = 0;
    // When set, neither side idles: the closing part of the run.
    bit calm = 1'b0;
    // Asks the result side for its one long hold-off.
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    text_terminal_screen_engine_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    screen_shadow_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .cfg             (cfg_ch),
        .view_mismatches (view_mismatches),
        .views_pending   (views_pending)
    );

    always #5 clk = ~clk;

    // Sends one command word. Valid is left high after acceptance so that words can
    // follow back to back; an idle burst or the drain step lowers it at a falling edge.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] b,
                             input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= cmd;
        item_ch.byte_value <= b;
        item_ch.read_row   <= r;
        item_ch.read_col   <= c;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        if (cmd == CMD_READ || cmd == CMD_CLEAR ||
            (cmd == CMD_PUT && ((b >= CH_PRINT_LO && b <= CH_PRINT_HI) ||
                                b == CH_LF || b == CH_CR || b == CH_BS || b == CH_TAB)))
        begin
            counted_words++;
        end
    endtask

    // The address fields are don't-care for a put, so they carry random bits.
    task automatic put_byte(input logic [CHAR_W-1:0] b);
        send_word(CMD_PUT, b, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        send_word(CMD_READ, CHAR_W'($urandom), r, c);
    endtask

    // Register writes happen only with the item side quiet and every result in.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Lowers valid and waits until every expected word has come back.
    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (views_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One random stretch of traffic. Most of it is text: lines of printable bytes with
    // the odd tab or backspace, ended by a newline. Short lines are the rule so that
    // the screen fills and scrolls; a few long ones wrap and reach the tab clamp.
    task automatic random_segment();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    put_byte(($urandom_range(0, 1) == 0) ? CH_TAB : CH_BS);
                end
                else
                begin
                    put_byte(CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                put_byte(CH_CR);
            end
            put_byte(CH_LF);
        end
        else if (kind < 70)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 3))
                    0: put_byte(CH_BS);
                    1: put_byte(CH_TAB);
                    2: put_byte(CH_CR);
                    default: put_byte(CH_LF);
                endcase
            end
        end
        else if (kind < 85)
        begin
            // Reads stay mostly on the screen; some land beyond it and saturate.
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    read_cell(ROW_W'($urandom), COL_W'($urandom));
                end
                else
                begin
                    read_cell(ROW_W'($urandom_range(0, SCREEN_ROWS - 1)),
                              COL_W'($urandom_range(0, SCREEN_COLS - 1)));
                end
            end
        end
        else if (kind < 99)
        begin
            // Noise: any byte at all, or the unused command.
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    send_word(CMD_UNUSED, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
                end
                else
                begin
                    put_byte(CHAR_W'($urandom));
                end
            end
        end
        else
        begin
            send_word(CMD_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        end
    endtask

    task automatic random_phase(input int target);
        int start;
        start = counted_words;
        while (counted_words - start < target)
        begin
            random_segment();
        end
    endtask

    // Result side: ready drops in short random bursts, once for a long stretch when
    // asked, and stays high in the closing part of the run.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                result_ch.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Hard limit on the run, far beyond the slowest correct one.
    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.cmd        = CMD_PUT;
        item_ch.byte_value = '0;
        item_ch.read_row   = '0;
        item_ch.read_col   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_FG;
        cfg_ch.data        = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Start from the reset colors, and poke the two unused register indexes,
        // which must leave the colors alone.
        write_reg(REG_FG, 24'hFFFFFF);
        write_reg(REG_BG, 24'h000000);
        write_reg(REG_SPARE_A, COLOR_W'($urandom));
        write_reg(REG_SPARE_B, COLOR_W'($urandom));

        // Directed part. Reads first, on the blank screen: corners, and addresses
        // past the last row or column, which saturate.
        read_cell(5'd0, 7'd0);
        read_cell(5'd31, 7'd127);
        read_cell(5'd24, 7'd79);
        read_cell(5'd30, 7'd3);
        read_cell(5'd2, 7'd100);
        // Printable range edges, then bytes the block ignores.
        put_byte(8'h41);
        put_byte(CH_PRINT_LO);
        put_byte(CH_PRINT_HI);
        put_byte(CH_DEL);
        put_byte(8'hFF);
        put_byte(CH_ESC);
        put_byte(8'h00);
        // Tab, backspace, carriage return, then backspace at the home position,
        // which does nothing.
        put_byte(CH_TAB);
        put_byte(CH_BS);
        put_byte(CH_CR);
        put_byte(CH_BS);
        // Backspace at the start of row 1 goes back to the last column of row 0,
        // and a character written there wraps to the next row.
        put_byte(CH_LF);
        put_byte(CH_BS);
        put_byte(8'h5A);
        send_word(CMD_UNUSED, 8'hA5, 5'd31, 7'd127);
        read_cell(5'd0, 7'd79);
        send_word(CMD_CLEAR, 8'h5A, 5'd0, 7'd0);
        read_cell(5'd0, 7'd0);
        drain_results();

        // Opposite color extremes, and the long hold-off on the result side while
        // the item side keeps sending.
        write_reg(REG_FG, 24'h000000);
        write_reg(REG_BG, 24'hFFFFFF);
        hold_req = 1'b1;
        random_phase(PHASE_WORDS);
        drain_results();

        write_reg(REG_FG, COLOR_W'($urandom));
        write_reg(REG_BG, COLOR_W'($urandom));
        random_phase(PHASE_WORDS);
        drain_results();

        write_reg(REG_BG, COLOR_W'($urandom));
        write_reg(REG_FG, COLOR_W'($urandom));
        random_phase(PHASE_WORDS);
        drain_results();

        // Closing part: no idling on either side.
        write_reg(REG_FG, COLOR_W'($urandom));
        write_reg(REG_BG, COLOR_W'($urandom));
        calm = 1'b1;
        random_phase(PHASE_WORDS);
        drain_results();

        if (view_mismatches == 0 && views_pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
